/* src/ptex_pkg.sv */
// Shared types, constants and helpers for the palette texel expander.
// Used by the palette RAM, the top level and the port checker.
package ptex_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int RAM_AW          = PAL_AW + 1;
    localparam int RAM_DEPTH       = 2 * PALETTE_ENTRIES;
    localparam int IDX_W           = 8;
    localparam int COLOUR_W        = 24;
    localparam int TEXEL_W         = 16;
    localparam int CFG_IDX_W       = 1;

    localparam logic [IDX_W:0] PAL_LIMIT = (IDX_W + 1)'(PALETTE_ENTRIES);

    typedef enum logic [1:0] {
        REQ_PAL_WRITE = 2'd0,
        REQ_INDEXED   = 2'd1,
        REQ_DIRECT    = 2'd2
    } req_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PALETTE_BANK = 1'b0,
        CFG_INDEX_ALPHA  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]          req_type;
        logic                bank;
        logic [IDX_W-1:0]    index;
        logic [COLOUR_W-1:0] colour;
        logic [TEXEL_W-1:0]  direct_texel;
        logic                final_texel;
    } req_t;

    typedef struct packed {
        logic [TEXEL_W-1:0] pixel;
        logic               alpha_mixed;
        logic               texture_done;
    } rsp_t;

    typedef struct packed {
        logic                we;
        logic [RAM_AW-1:0]   addr;
        logic [COLOUR_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic              re;
        logic [RAM_AW-1:0] addr;
    } ram_rd_t;

    // Keep the top five bits of each channel: blue, green, red from low to high.
    function automatic logic [TEXEL_W-1:0] pack555(input logic [COLOUR_W-1:0] c);
        return {1'b0, c[23:19], c[15:11], c[7:3]};
    endfunction

endpackage

/* src/ptex_palette_ram.sv */
// Palette storage: both banks in one synchronous RAM, one write and one read port.
// Depends on ptex_pkg for depth, widths and port structs.
module ptex_palette_ram
    import ptex_pkg::*;
(
    input  logic                clk,
    input  ram_wr_t             wr,
    input  ram_rd_t             rd,
    output logic [COLOUR_W-1:0] rdata
);

    logic [COLOUR_W-1:0] mem [RAM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read data registered; hold it while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd.re)
        begin
            rdata <= mem[rd.addr];
        end
    end

endmodule

/* src/palette_texel_expand_alpha_detect.sv */
// Top level: palette texel expander with per-texture alpha-mix detection.
// Depends on ptex_pkg and ptex_palette_ram.
// A texel beat accepted passes through stage 1 (palette read) and the output
// register before it shows. Throughput: one beat per cycle unless the response
// channel stalls; the palette RAM's single read port sets it.
// Reset (rst_n low, asynchronous): pipeline empty, palette_bank 0, index alpha
// rule on, tracking waits for a first texel. Palette RAM is not cleared.
module palette_texel_expand_alpha_detect
    import ptex_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    // response channel
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    // Configuration registers
    logic palette_bank_reg, palette_bank_next;
    logic idx_alpha_reg, idx_alpha_next;

    // Stage 1: texel waiting for its palette read data
    logic s1_valid_reg, s1_valid_next;
    logic s1_indexed_reg;
    logic s1_in_range_reg;
    logic s1_idx_zero_reg;
    logic s1_final_reg;
    logic [TEXEL_W-1:0] s1_direct_reg;

    // Per-texture alpha tracking
    logic awaiting_reg, awaiting_next;
    logic first_bit_reg, first_bit_next;
    logic mixed_reg, mixed_next;

    // Output register
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg;

    logic                req_accept;
    logic                is_write;
    logic                is_texel;
    logic                in_range;
    logic                s1_adv;
    logic [COLOUR_W-1:0] ram_rdata;
    logic [COLOUR_W-1:0] colour;
    logic [TEXEL_W-1:0]  pixel;
    logic                mixed_now;
    ram_wr_t             ram_wr;
    ram_rd_t             ram_rd;

    assign cfg_ready = 1'b1;

    // Stage 1 drains when the output register is empty or being taken;
    // take a new beat whenever stage 1 is empty or drains this cycle.
    assign s1_adv     = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready  = !s1_valid_reg || s1_adv;
    assign req_accept = req_valid && req_ready;

    assign is_write = (req.req_type == REQ_PAL_WRITE);
    assign is_texel = (req.req_type == REQ_INDEXED) || (req.req_type == REQ_DIRECT);
    assign in_range = ({1'b0, req.index} < PAL_LIMIT);

    // Writes and reads issue at accept; items are accepted at most one per edge in
    // order, so a read always sees every earlier write and no forwarding is needed.
    assign ram_wr.we   = req_accept && is_write && in_range;
    assign ram_wr.addr = {req.bank, req.index[PAL_AW-1:0]};
    assign ram_wr.data = req.colour;

    assign ram_rd.re   = req_accept && (req.req_type == REQ_INDEXED);
    assign ram_rd.addr = {palette_bank_reg, req.index[PAL_AW-1:0]};

    ptex_palette_ram u_palette_ram (
        .clk   (clk),
        .wr    (ram_wr),
        .rd    (ram_rd),
        .rdata (ram_rdata)
    );

    // Form the pixel from read data; an index beyond the palette reads colour zero
    always_comb
    begin
        colour = s1_in_range_reg ? ram_rdata : '0;
        if (s1_indexed_reg)
        begin
            pixel = pack555(colour);
            if (idx_alpha_reg)
            begin
                pixel[TEXEL_W-1] = !s1_idx_zero_reg;
            end
        end
        else
        begin
            pixel = s1_direct_reg;
        end
        mixed_now = awaiting_reg ? mixed_reg
                                 : (mixed_reg || (pixel[TEXEL_W-1] != first_bit_reg));
    end

    always_comb
    begin
        palette_bank_next = palette_bank_reg;
        idx_alpha_next    = idx_alpha_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PALETTE_BANK: palette_bank_next = cfg_data;
                CFG_INDEX_ALPHA:  idx_alpha_next    = cfg_data;
                default:          ;
            endcase
        end

        s1_valid_next = s1_valid_reg;
        if (req_accept && is_texel)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (s1_adv)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        // Advance tracking as each texel leaves stage 1; restart after the final one
        awaiting_next  = awaiting_reg;
        first_bit_next = first_bit_reg;
        mixed_next     = mixed_reg;
        if (s1_adv)
        begin
            if (s1_final_reg)
            begin
                awaiting_next  = 1'b1;
                first_bit_next = 1'b0;
                mixed_next     = 1'b0;
            end
            else if (awaiting_reg)
            begin
                awaiting_next  = 1'b0;
                first_bit_next = pixel[TEXEL_W-1];
            end
            else
            begin
                mixed_next = mixed_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_bank_reg <= 1'b0;
            idx_alpha_reg    <= 1'b1;
            s1_valid_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            awaiting_reg     <= 1'b1;
            first_bit_reg    <= 1'b0;
            mixed_reg        <= 1'b0;
        end
        else
        begin
            palette_bank_reg <= palette_bank_next;
            idx_alpha_reg    <= idx_alpha_next;
            s1_valid_reg     <= s1_valid_next;
            rsp_valid_reg    <= rsp_valid_next;
            awaiting_reg     <= awaiting_next;
            first_bit_reg    <= first_bit_next;
            mixed_reg        <= mixed_next;
        end
    end

    // Payload registers: stage 1 loads on texel accept, output on advance; hold otherwise
    always_ff @(posedge clk)
    begin
        if (req_accept && is_texel)
        begin
            s1_indexed_reg  <= (req.req_type == REQ_INDEXED);
            s1_in_range_reg <= in_range;
            s1_idx_zero_reg <= (req.index == '0);
            s1_final_reg    <= req.final_texel;
            s1_direct_reg   <= req.direct_texel;
        end
        if (s1_adv)
        begin
            rsp_reg.pixel        <= pixel;
            rsp_reg.alpha_mixed  <= mixed_now;
            rsp_reg.texture_done <= s1_final_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* src/ptex_checker.sv */
// Port-level checker for the palette texel expander, bound to the top level.
// Depends on ptex_pkg for the response beat type.
module ptex_checker
    import ptex_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    logic rsp_fire;
    logic at_start_reg;
    logic mixed_seen_reg;

    assign rsp_fire = rsp_valid && rsp_ready;

    // Track texture boundaries and the last delivered flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg   <= 1'b1;
            mixed_seen_reg <= 1'b0;
        end
        else if (rsp_fire)
        begin
            at_start_reg   <= rsp.texture_done;
            mixed_seen_reg <= rsp.alpha_mixed && !rsp.texture_done;
        end
    end

    a_rsp_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response valid dropped before accept");

    a_rsp_beat_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp))
        else $error("response beat changed while stalled");

    a_first_not_mixed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && at_start_reg |-> !rsp.alpha_mixed)
        else $error("first texel of a texture reports mixed alpha");

    a_mixed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && mixed_seen_reg |-> rsp.alpha_mixed)
        else $error("mixed alpha flag cleared inside a texture");

endmodule

bind palette_texel_expand_alpha_detect ptex_checker u_ptex_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
